### rtl/core/hrq_pkg.sv
`timescale 1ns / 1ps
package hrq_pkg;
   localparam int ID_W         = 8;
   localparam int EST_W        = 16;
   localparam int WAIT_W       = 16;
   localparam int AGE_W        = 8;
   localparam int KIND_W       = 2;
   localparam int STATUS_W     = 2;
   localparam int DEFAULT_DEPTH = 16;

   localparam logic [KIND_W-1:0] KIND_ENQUEUE  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_DISPATCH = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TICK     = 2'd2;

   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

   typedef struct packed {
      logic              valid;
      logic [ID_W-1:0]   id;
      logic [WAIT_W-1:0] snap;
      logic [EST_W-1:0]  est;
      logic              pre;
      logic              unb;
      logic [AGE_W-1:0]  elapsed;
   } cand_type;

   typedef struct packed {
      logic              wr;
      logic              tick;
      logic              clr;
      logic [ID_W-1:0]   id;
      logic [EST_W-1:0]  est;
      logic [WAIT_W-1:0] wait_val;
      logic              pre;
      logic              unb;
      logic [AGE_W-1:0]  arrival;
   } ctl_type;
endpackage

### rtl/core/hrq_cell.sv
`timescale 1ns / 1ps
module hrq_cell
   import hrq_pkg::*;
#(
   parameter int IW = 4,
   parameter logic [IW-1:0] SLOT = '0
) (
   input  logic          clock,
   input  logic          reset,
   input  ctl_type       ctl,
   input  logic          sel,
   input  cand_type      cand_in,
   input  logic [IW-1:0] idx_in,
   output cand_type      cand_out,
   output logic [IW-1:0] idx_out,
   output logic          valid
);
   logic              valid_ff;
   logic [ID_W-1:0]   id_ff;
   logic [EST_W-1:0]  est_ff;
   logic [WAIT_W-1:0] wait_ff;
   logic [WAIT_W-1:0] snap_ff;
   logic              pre_ff;
   logic              unb_ff;
   logic [AGE_W-1:0]  age_ff;
   cand_type          cand_ff;
   cand_type          cand_in_mine;
   logic [IW-1:0]     idx_ff;
   logic [EST_W-1:0]  eff_est;
   logic [31:0]       lhs, rhs;
   logic              beats, take;

   assign eff_est = (est_ff == '0) ? EST_W'(1) : est_ff;
   assign lhs = 32'(snap_ff) * 32'(cand_in.est);
   assign rhs = 32'(cand_in.snap) * 32'(eff_est);

   always_comb begin
      cand_in_mine.valid   = 1'b1;
      cand_in_mine.id      = id_ff;
      cand_in_mine.snap    = snap_ff;
      cand_in_mine.est     = eff_est;
      cand_in_mine.pre     = pre_ff;
      cand_in_mine.unb     = unb_ff;
      cand_in_mine.elapsed = ctl.arrival - age_ff;
      priority if (lhs != rhs) beats = lhs > rhs;
      else if (pre_ff != cand_in.pre) beats = !pre_ff;
      else if (unb_ff != cand_in.unb) beats = unb_ff;
      else beats = cand_in_mine.elapsed > cand_in.elapsed;
      take = valid_ff && (!cand_in.valid || beats);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cand_ff <= '0;
         idx_ff  <= '0;
      end else begin
         cand_ff <= take ? cand_in_mine : cand_in;
         idx_ff  <= take ? SLOT : idx_in;
      end
      if (ctl.wr && sel) begin
         id_ff   <= ctl.id;
         est_ff  <= ctl.est;
         wait_ff <= ctl.wait_val;
         snap_ff <= ctl.wait_val;
         pre_ff  <= ctl.pre;
         unb_ff  <= ctl.unb;
         age_ff  <= ctl.arrival;
      end else if (ctl.wr) begin
         snap_ff <= wait_ff;
      end else if (ctl.clr && sel) begin
         wait_ff <= '0;
      end else if (ctl.tick && valid_ff && wait_ff != '1) begin
         wait_ff <= wait_ff + WAIT_W'(1);
      end
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctl.wr && sel) begin
         valid_ff <= 1'b1;
      end else if (ctl.clr && sel) begin
         valid_ff <= 1'b0;
      end
   end

   assign cand_out = cand_ff;
   assign idx_out  = idx_ff;
   assign valid    = valid_ff;
endmodule

### rtl/core/hrrn_ready_queue.sv
`timescale 1ns / 1ps
// Ready table for a highest-response-ratio-next scheduler. Issue a request
// with start while busy is low; its result appears, registered, on the
// rsp_ ports for exactly one cycle with rsp_valid, and cannot be stalled.
// Enqueue, tick, unused kinds and a dispatch on an empty table answer in
// the cycle after acceptance. A dispatch on a nonempty table passes a
// best-so-far candidate along the chain of QUEUE_DEPTH slot cells, one
// cell per cycle, answering after SCAN and FINISH; busy is high meanwhile.
module hrrn_ready_queue
   import hrq_pkg::*;
#(
   parameter int QUEUE_DEPTH = DEFAULT_DEPTH
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  logic [KIND_W-1:0]                req_kind,
   input  logic [ID_W-1:0]                  req_proc_id,
   input  logic [EST_W-1:0]                 req_burst_estimate,
   input  logic [WAIT_W-1:0]                req_initial_wait,
   input  logic                             req_recently_preempted,
   input  logic                             req_recently_unblocked,
   output logic                             rsp_valid,
   output logic [STATUS_W-1:0]              rsp_status,
   output logic [ID_W-1:0]                  rsp_chosen_id,
   output logic [$clog2(QUEUE_DEPTH+1)-1:0] rsp_queued_count
);
   localparam int IW = $clog2(QUEUE_DEPTH);
   localparam int CW = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {IDLE, SCAN, FINISH} state_type;

   state_type         state_ff;
   logic [IW-1:0]     cnt_ff;
   logic [CW-1:0]     count_ff;
   logic [AGE_W-1:0]  arrival_ff;
   logic              rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ID_W-1:0]   rsp_id_ff;
   ctl_type           ctl;
   logic [QUEUE_DEPTH-1:0] valid_vec, sel_vec;
   logic [IW-1:0]     free_idx;
   logic              accept;
   cand_type          chain [QUEUE_DEPTH+1];
   logic [IW-1:0]     idx_chain [QUEUE_DEPTH+1];

   assign accept = start && (state_ff == IDLE);
   assign busy   = (state_ff != IDLE);

   always_comb begin
      free_idx = '0;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--)
         if (!valid_vec[i]) free_idx = IW'(i);
      ctl.wr       = accept && req_kind == KIND_ENQUEUE && count_ff != CW'(QUEUE_DEPTH);
      ctl.tick     = accept && req_kind == KIND_TICK;
      ctl.clr      = (state_ff == FINISH);
      ctl.id       = req_proc_id;
      ctl.est      = req_burst_estimate;
      ctl.wait_val = req_initial_wait;
      ctl.pre      = req_recently_preempted;
      ctl.unb      = req_recently_unblocked;
      ctl.arrival  = arrival_ff;
      for (int i = 0; i < QUEUE_DEPTH; i++)
         sel_vec[i] = ctl.clr ? (idx_chain[QUEUE_DEPTH] == IW'(i)) : (free_idx == IW'(i));
   end

   assign chain[0]     = '0;
   assign idx_chain[0] = '0;

   for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
      hrq_cell #(.IW(IW), .SLOT(IW'(g))) u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl),
         .sel      (sel_vec[g]),
         .cand_in  (chain[g]),
         .idx_in   (idx_chain[g]),
         .cand_out (chain[g+1]),
         .idx_out  (idx_chain[g+1]),
         .valid    (valid_vec[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         cnt_ff        <= '0;
         count_ff      <= '0;
         arrival_ff    <= '0;
         rsp_valid_ff  <= 1'b0;
         rsp_status_ff <= STATUS_DONE;
         rsp_id_ff     <= '0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  rsp_status_ff <= STATUS_DONE;
                  rsp_id_ff     <= '0;
                  unique case (req_kind)
                     KIND_ENQUEUE: begin
                        rsp_valid_ff <= 1'b1;
                        if (ctl.wr) begin
                           count_ff   <= count_ff + CW'(1);
                           arrival_ff <= arrival_ff + AGE_W'(1);
                        end else begin
                           rsp_status_ff <= STATUS_FULL;
                        end
                     end
                     KIND_DISPATCH: begin
                        if (count_ff == '0) begin
                           rsp_valid_ff  <= 1'b1;
                           rsp_status_ff <= STATUS_EMPTY;
                        end else begin
                           state_ff <= SCAN;
                           cnt_ff   <= '0;
                        end
                     end
                     default: rsp_valid_ff <= 1'b1;
                  endcase
               end
            end
            SCAN: begin
               cnt_ff <= cnt_ff + IW'(1);
               if (cnt_ff == IW'(QUEUE_DEPTH - 1)) state_ff <= FINISH;
            end
            FINISH: begin
               rsp_valid_ff  <= 1'b1;
               rsp_status_ff <= STATUS_DONE;
               rsp_id_ff     <= chain[QUEUE_DEPTH].id;
               count_ff      <= count_ff - CW'(1);
               state_ff      <= IDLE;
            end
            default: state_ff <= IDLE;
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_chosen_id    = rsp_id_ff;
   assign rsp_queued_count = count_ff;
endmodule

### verif/tb_hrrn_ready_queue.sv
`timescale 1ns / 1ps
module tb_hrrn_ready_queue;
   import hrq_pkg::*;

   localparam int DEPTH = DEFAULT_DEPTH;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
   localparam int IDLE_LIMIT = 2000;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ID_W-1:0]     chosen;
      logic [CNT_W-1:0]    count;
   } sched_result_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [KIND_W-1:0]   req_kind = KIND_TICK;
   logic [ID_W-1:0]     req_proc_id = '0;
   logic [EST_W-1:0]    req_burst_estimate = '0;
   logic [WAIT_W-1:0]   req_initial_wait = '0;
   logic                req_recently_preempted = 1'b0;
   logic                req_recently_unblocked = 1'b0;
   logic                rsp_valid;
   logic [STATUS_W-1:0] rsp_status;
   logic [ID_W-1:0]     rsp_chosen_id;
   logic [CNT_W-1:0]    rsp_queued_count;

   hrrn_ready_queue #(.QUEUE_DEPTH(DEPTH)) uut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_kind(req_kind), .req_proc_id(req_proc_id),
      .req_burst_estimate(req_burst_estimate), .req_initial_wait(req_initial_wait),
      .req_recently_preempted(req_recently_preempted),
      .req_recently_unblocked(req_recently_unblocked),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_chosen_id(rsp_chosen_id), .rsp_queued_count(rsp_queued_count)
   );

   always #6 clock = ~clock;

   // shadow ready table
   logic [ID_W-1:0]   tbl_id   [DEPTH];
   logic [EST_W-1:0]  tbl_est  [DEPTH];
   logic [WAIT_W-1:0] tbl_wait [DEPTH];
   logic [WAIT_W-1:0] tbl_snap [DEPTH];
   logic              tbl_pre  [DEPTH];
   logic              tbl_unb  [DEPTH];
   logic [AGE_W-1:0]  tbl_age  [DEPTH];
   logic              tbl_live [DEPTH];
   logic [AGE_W-1:0]  arrivals;

   sched_result_type pending_results[$];
   int errors = 0;
   int n_enq = 0, n_full = 0, n_disp = 0, n_empty = 0, n_tick = 0, n_other = 0;
   int n_rsp = 0;
   int idle_cycles = 0;

   function automatic logic [31:0] eff_est(int i);
      return (tbl_est[i] == '0) ? 32'd1 : {16'd0, tbl_est[i]};
   endfunction

   function automatic bit outranks(int a, int b);
      logic [31:0] lhs, rhs;
      logic [AGE_W-1:0] age_a, age_b;
      lhs = {16'd0, tbl_snap[a]} * eff_est(b);
      rhs = {16'd0, tbl_snap[b]} * eff_est(a);
      if (lhs != rhs) return lhs > rhs;
      if (tbl_pre[a] != tbl_pre[b]) return !tbl_pre[a];
      if (tbl_unb[a] != tbl_unb[b]) return tbl_unb[a];
      age_a = arrivals - tbl_age[a];
      age_b = arrivals - tbl_age[b];
      if (age_a != age_b) return age_a > age_b;
      return a < b;
   endfunction

   task automatic schedule_request(input logic [KIND_W-1:0] k, input logic [ID_W-1:0] pid,
                                   input logic [EST_W-1:0] est, input logic [WAIT_W-1:0] w,
                                   input logic pre, input logic unb);
      sched_result_type r;
      int slot, best, cnt;
      r = '0;
      if (k == KIND_ENQUEUE) begin
         slot = -1;
         for (int i = 0; i < DEPTH; i++)
            if (!tbl_live[i] && slot < 0) slot = i;
         if (slot < 0) begin
            r.status = STATUS_FULL;
            n_full++;
         end else begin
            tbl_id[slot] = pid; tbl_est[slot] = est; tbl_wait[slot] = w;
            tbl_pre[slot] = pre; tbl_unb[slot] = unb; tbl_age[slot] = arrivals;
            tbl_live[slot] = 1'b1;
            arrivals++;
            for (int i = 0; i < DEPTH; i++)
               if (tbl_live[i]) tbl_snap[i] = tbl_wait[i];
            n_enq++;
         end
      end else if (k == KIND_DISPATCH) begin
         best = -1;
         for (int i = 0; i < DEPTH; i++)
            if (tbl_live[i] && (best < 0 || outranks(i, best))) best = i;
         if (best < 0) begin
            r.status = STATUS_EMPTY;
            n_empty++;
         end else begin
            r.chosen = tbl_id[best];
            tbl_wait[best] = '0;
            tbl_live[best] = 1'b0;
            n_disp++;
         end
      end else if (k == KIND_TICK) begin
         for (int i = 0; i < DEPTH; i++)
            if (tbl_live[i] && tbl_wait[i] != '1) tbl_wait[i]++;
         n_tick++;
      end else begin
         n_other++;
      end
      cnt = 0;
      for (int i = 0; i < DEPTH; i++) cnt += tbl_live[i];
      r.count = CNT_W'(cnt);
      pending_results.push_back(r);
   endtask

   // called at a falling edge; returns at the falling edge after acceptance
   task automatic send_request(input logic [KIND_W-1:0] k, input logic [ID_W-1:0] pid,
                               input logic [EST_W-1:0] est, input logic [WAIT_W-1:0] w,
                               input logic pre, input logic unb);
      int gap;
      gap = int'($urandom_range(0, 4));
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_kind = k; req_proc_id = pid; req_burst_estimate = est;
      req_initial_wait = w; req_recently_preempted = pre; req_recently_unblocked = unb;
      start = 1'b1;
      while (busy) @(negedge clock);
      schedule_request(k, pid, est, w, pre, unb);
      @(negedge clock);
   endtask

   task automatic enqueue(input logic [ID_W-1:0] pid, input logic [EST_W-1:0] est,
                          input logic [WAIT_W-1:0] w, input logic pre, input logic unb);
      send_request(KIND_ENQUEUE, pid, est, w, pre, unb);
   endtask

   task automatic simple_request(input logic [KIND_W-1:0] k);
      send_request(k, ID_W'($urandom), EST_W'($urandom), WAIT_W'($urandom),
                   1'($urandom), 1'($urandom));
   endtask

   always @(posedge clock) begin
      sched_result_type e;
      if (!reset && rsp_valid) begin
         n_rsp++;
         if (pending_results.size() == 0) begin
            $display("%0t: unexpected result status=%0d id=%0d count=%0d", $time,
                     rsp_status, rsp_chosen_id, rsp_queued_count);
            errors++;
         end else begin
            e = pending_results.pop_front();
            if (rsp_status !== e.status) begin
               $display("%0t: status expected %0d actual %0d", $time, e.status, rsp_status);
               errors++;
            end
            if (rsp_chosen_id !== e.chosen) begin
               $display("%0t: chosen_id expected %0d actual %0d", $time, e.chosen,
                        rsp_chosen_id);
               errors++;
            end
            if (rsp_queued_count !== e.count) begin
               $display("%0t: queued_count expected %0d actual %0d", $time, e.count,
                        rsp_queued_count);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time, pending_results.size());
         $display("*** FAILED ***");
         $finish;
      end
   end

   task automatic test_empty_table;
      simple_request(KIND_DISPATCH);
      simple_request(KIND_TICK);
      simple_request(KIND_UNUSED);
   endtask

   task automatic test_field_extremes;
      enqueue(8'd0, 16'd0, 16'hFFFF, 1'b0, 1'b0);
      enqueue(8'd255, 16'hFFFF, 16'd0, 1'b1, 1'b1);
      enqueue(8'd17, 16'd1, 16'hFFFE, 1'b0, 1'b1);
      simple_request(KIND_TICK);
      simple_request(KIND_TICK);
      enqueue(8'd18, 16'd1, 16'hFFFF, 1'b1, 1'b0);
      repeat (5) simple_request(KIND_DISPATCH);
   endtask

   task automatic test_tie_breaks;
      enqueue(8'd1, 16'd2, 16'd4, 1'b1, 1'b1);
      enqueue(8'd2, 16'd3, 16'd6, 1'b0, 1'b0);
      enqueue(8'd3, 16'd1, 16'd2, 1'b0, 1'b1);
      enqueue(8'd4, 16'd4, 16'd8, 1'b0, 1'b1);
      enqueue(8'd5, 16'd0, 16'd2, 1'b0, 1'b0);
      repeat (5) simple_request(KIND_DISPATCH);
   endtask

   task automatic test_full_table;
      for (int i = 0; i <= DEPTH; i++)
         enqueue(ID_W'($urandom), EST_W'($urandom_range(0, 3)),
                 WAIT_W'($urandom_range(0, 3)), 1'($urandom), 1'($urandom));
      simple_request(KIND_TICK);
      for (int i = 0; i <= DEPTH; i++) simple_request(KIND_DISPATCH);
   endtask

   // one stale entry stays queued while the arrival counter wraps
   task automatic test_arrival_wrap;
      enqueue(8'hA5, 16'hFFFF, 16'd0, 1'b0, 1'b0);
      for (int i = 0; i < 290; i++) begin
         enqueue(ID_W'($urandom), EST_W'($urandom_range(1, 50)),
                 WAIT_W'($urandom_range(1, 100)), 1'($urandom), 1'($urandom));
         simple_request(KIND_DISPATCH);
      end
      enqueue(8'h5A, 16'd7, 16'd0, 1'b0, 1'b0);
      simple_request(KIND_DISPATCH);
      simple_request(KIND_DISPATCH);
   endtask

   task automatic test_random_mix;
      int sel;
      logic [EST_W-1:0] est;
      logic [WAIT_W-1:0] w;
      for (int i = 0; i < 1050; i++) begin
         sel = int'($urandom_range(0, 99));
         est = ($urandom_range(0, 3) == 0) ? EST_W'($urandom) : EST_W'($urandom_range(0, 6));
         w = ($urandom_range(0, 3) == 0) ? WAIT_W'($urandom) : WAIT_W'($urandom_range(0, 12));
         if (sel < 42) enqueue(ID_W'($urandom), est, w, 1'($urandom), 1'($urandom));
         else if (sel < 70) simple_request(KIND_DISPATCH);
         else if (sel < 95) simple_request(KIND_TICK);
         else simple_request(KIND_UNUSED);
      end
   endtask

   initial begin
      for (int i = 0; i < DEPTH; i++) tbl_live[i] = 1'b0;
      arrivals = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_empty_table();
      test_field_extremes();
      test_tie_breaks();
      test_full_table();
      test_arrival_wrap();
      test_random_mix();
      start = 1'b0;
      while (pending_results.size() != 0) @(negedge clock);
      repeat (DEPTH + 4) @(negedge clock);
      $display("Requests: %0d enqueued, %0d full, %0d dispatched, %0d empty, %0d ticks,",
               n_enq, n_full, n_disp, n_empty, n_tick);
      $display("%0d unused kind; %0d results checked, %0d mismatches", n_other, n_rsp, errors);
      if (errors == 0 && pending_results.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
